// File: src/pfd_pkg.sv
// Shared types and constants for the position frame deframer.
package pfd_pkg;

    localparam int PAYLOAD_BYTES = 24;
    localparam int IDX_W         = 5;

    typedef logic [7:0]       byte_t;
    typedef logic [31:0]      word_t;
    typedef logic [IDX_W-1:0] idx_t;

    localparam byte_t BYTE_CR = 8'h0D;
    localparam byte_t BYTE_LF = 8'h0A;

    localparam idx_t LAST_IDX = idx_t'(PAYLOAD_BYTES - 1);

    // payload byte offsets of the words that are kept
    localparam idx_t ANGLE_LO = idx_t'(0);
    localparam idx_t ANGLE_HI = idx_t'(3);
    localparam idx_t X_LO     = idx_t'(12);
    localparam idx_t X_HI     = idx_t'(15);
    localparam idx_t Y_LO     = idx_t'(16);
    localparam idx_t Y_HI     = idx_t'(19);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_HDR2 = 3'd1,
        PH_DATA = 3'd2,
        PH_TRL1 = 3'd3,
        PH_TRL2 = 3'd4
    } phase_t;

    typedef struct packed {
        word_t angle_bits;
        word_t pos_x_bits;
        word_t pos_y_bits;
    } pos_t;

endpackage

// File: src/pfd_byte_if.sv
// Byte channel: valid/ready handshake carrying one received serial byte.
interface pfd_byte_if;
    logic          valid;
    logic          ready;
    pfd_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: src/pfd_pos_if.sv
// Position channel: valid/ready handshake carrying one decoded frame.
interface pfd_pos_if;
    logic          valid;
    logic          ready;
    pfd_pkg::word_t angle_bits;
    pfd_pkg::word_t pos_x_bits;
    pfd_pkg::word_t pos_y_bits;

    modport source (output valid, output angle_bits, output pos_x_bits,
                    output pos_y_bits, input ready);
    modport sink   (input valid, input angle_bits, input pos_x_bits,
                    input pos_y_bits, output ready);
endinterface

// File: src/pfd_parser.sv
// Frame parser: header/payload/trailer state machine and word assembly.
module pfd_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  pfd_pkg::byte_t rx_byte,
    output logic           emit,
    output pfd_pkg::pos_t  res
);
    import pfd_pkg::*;

    phase_t phase_reg, phase_next;
    idx_t   idx_reg, idx_next;
    word_t  angle_reg, angle_next;
    word_t  x_reg, x_next;
    word_t  y_reg, y_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        angle_next = angle_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        if (fire)
        begin
            case (phase_reg)
                PH_HDR2:
                begin
                    if (rx_byte == BYTE_LF)
                    begin
                        phase_next = PH_DATA;
                        idx_next   = '0;
                    end
                    else if (rx_byte != BYTE_CR)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    if (idx_reg inside {[ANGLE_LO:ANGLE_HI]})
                        angle_next[{idx_reg[1:0], 3'b000} +: 8] = rx_byte;
                    else if (idx_reg inside {[X_LO:X_HI]})
                        x_next[{idx_reg[1:0], 3'b000} +: 8] = rx_byte;
                    else if (idx_reg inside {[Y_LO:Y_HI]})
                        y_next[{idx_reg[1:0], 3'b000} +: 8] = rx_byte;
                    if (idx_reg == LAST_IDX)
                    begin
                        phase_next = PH_TRL1;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + idx_t'(1);
                    end
                end
                PH_TRL1:
                begin
                    if (rx_byte == BYTE_LF)
                        phase_next = PH_TRL2;
                    else if (rx_byte == BYTE_CR)
                        phase_next = PH_HDR2;
                    else
                        phase_next = PH_HUNT;
                end
                PH_TRL2:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = (rx_byte == BYTE_CR) ? PH_HDR2 : PH_HUNT;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        emit           = fire && (phase_reg == PH_TRL2) && (rx_byte == BYTE_CR);
        res.angle_bits = angle_reg;
        res.pos_x_bits = x_reg;
        res.pos_y_bits = y_reg;
    end

    a_idx_zero_outside_data: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_DATA) |-> (idx_reg == '0))
        else $error("byte index not cleared outside payload");

    a_last_byte_to_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_DATA && idx_reg == LAST_IDX) |=> (phase_reg == PH_TRL1))
        else $error("last payload byte did not move to trailer");

    a_emit_then_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (phase_reg == PH_HUNT))
        else $error("parser not hunting after a good frame");

    a_cr_starts_header: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_HUNT && rx_byte == BYTE_CR) |=> (phase_reg == PH_HDR2))
        else $error("CR while hunting did not start a header");

endmodule

// File: src/pfd_out_stage.sv
// Result register: holds one decoded frame until the receiver takes it.
module pfd_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  pfd_pkg::pos_t din,
    output logic          space,
    pfd_pos_if.source     res
);
    import pfd_pkg::*;

    logic valid_reg, valid_next;
    pos_t data_reg;

    assign space = !valid_reg || res.ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (res.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= din;
    end

    assign res.valid      = valid_reg;
    assign res.angle_bits = data_reg.angle_bits;
    assign res.pos_x_bits = data_reg.pos_x_bits;
    assign res.pos_y_bits = data_reg.pos_y_bits;

endmodule

// File: src/position_frame_deframer_top.sv
// Top level of the position frame deframer.
//
// Usage:
//   rx  : byte items, one received serial byte each. The stream is parsed
//         continuously for frames of 0x0D 0x0A, 24 payload bytes, 0x0A 0x0D.
//   pos : one item per good frame, carrying the raw single-precision bits of
//         payload word 0 (angle), word 3 (x) and word 4 (y), little-endian.
//   Bytes of a bad frame are dropped; no item comes out for them.
// Throughput: one byte item per cycle, sustained, while pos is not stalled.
// Path: a frame's item reaches pos through the input register, which holds
//   its closing 0x0D, and then the result register, loaded when the parser
//   parses that byte.
// Reset (rst_n low, asynchronous): the parser goes back to hunting for a
//   header, the input register and the result register are emptied.
// Stall: while a result waits on pos and pos.ready is low, the byte held in
//   the input register is not parsed and rx.ready drops; no byte is lost.
module position_frame_deframer_top (
    input  logic       clk,
    input  logic       rst_n,
    pfd_byte_if.sink   rx,
    pfd_pos_if.source  pos
);
    import pfd_pkg::*;

    logic  stg_valid_reg, stg_valid_next;
    byte_t stg_byte_reg;
    logic  space;
    logic  fire;
    logic  rx_take;
    logic  emit;
    pos_t  res;

    // The registered byte is parsed when the result register can take
    // whatever the byte may produce.
    assign fire    = stg_valid_reg && space;
    assign rx.ready = !stg_valid_reg || space;
    assign rx_take = rx.valid && rx.ready;

    always_comb
    begin
        if (rx_take)
            stg_valid_next = 1'b1;
        else if (fire)
            stg_valid_next = 1'b0;
        else
            stg_valid_next = stg_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else
            stg_valid_reg <= stg_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
            stg_byte_reg <= rx.rx_byte;
    end

    pfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (stg_byte_reg),
        .emit    (emit),
        .res     (res)
    );

    pfd_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (emit),
        .din   (res),
        .space (space),
        .res   (pos)
    );

endmodule

// File: tb/sv/tb_position_frame_deframer_top.sv
// Testbench for position_frame_deframer_top: random byte streams, frame prediction, result check.
module tb_position_frame_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfd_pkg::*;

    // Run length and end-of-run margins
    localparam int unsigned STREAM_TARGET = 1650;   // minimum bytes in the whole stream
    localparam int unsigned DRAIN_CYCLES  = 20;     // quiet cycles after last frame
    localparam int unsigned CYCLE_LIMIT   = 500000; // hard stop

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pfd_byte_if rx_if ();
    pfd_pos_if  pos_if ();

    position_frame_deframer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .pos   (pos_if)
    );

    // Byte stream still to be sent, and frames the parser should emit
    byte_t       byte_stream[$];
    pos_t        pending_frames[$];
    int unsigned stream_len  = 0;
    int unsigned bytes_taken = 0;
    int unsigned mismatches  = 0;
    int unsigned cycles      = 0;

    // ------------------------------------------------------------------
    // Frame parser model: tracks header, payload and trailer of the stream.
    // ------------------------------------------------------------------
    phase_t frame_phase   = PH_HUNT;
    idx_t   payload_count = '0;
    word_t  angle_acc     = '0;
    word_t  x_acc         = '0;
    word_t  y_acc         = '0;

    // Takes one byte; returns 1 with the decoded frame when a trailer checks good.
    function automatic bit parse_byte(input byte_t b, output pos_t frame);
        bit found;
        found = 1'b0;
        frame = '0;
        case (frame_phase)
            PH_HDR2:
            begin
                // a repeated CR keeps waiting for the LF
                if (b == BYTE_LF)
                begin
                    frame_phase   = PH_DATA;
                    payload_count = '0;
                end
                else if (b != BYTE_CR)
                    frame_phase = PH_HUNT;
            end
            PH_DATA:
            begin
                // little-endian lanes; bytes of unused words are dropped
                if (payload_count <= ANGLE_HI)
                    angle_acc[{payload_count[1:0], 3'b000} +: 8] = b;
                else if (payload_count >= X_LO && payload_count <= X_HI)
                    x_acc[{payload_count[1:0], 3'b000} +: 8] = b;
                else if (payload_count >= Y_LO && payload_count <= Y_HI)
                    y_acc[{payload_count[1:0], 3'b000} +: 8] = b;
                if (payload_count == LAST_IDX)
                begin
                    frame_phase   = PH_TRL1;
                    payload_count = '0;
                end
                else
                    payload_count = payload_count + 1'b1;
            end
            PH_TRL1:
            begin
                // CR here restarts the header, anything else but LF drops the frame
                if (b == BYTE_LF)
                    frame_phase = PH_TRL2;
                else if (b == BYTE_CR)
                    frame_phase = PH_HDR2;
                else
                    frame_phase = PH_HUNT;
            end
            PH_TRL2:
            begin
                if (b == BYTE_CR)
                begin
                    frame.angle_bits = angle_acc;
                    frame.pos_x_bits = x_acc;
                    frame.pos_y_bits = y_acc;
                    found = 1'b1;
                end
                // closing CR is not the start of the next header
                frame_phase = PH_HUNT;
            end
            default:
                frame_phase = (b == BYTE_CR) ? PH_HDR2 : PH_HUNT;
        endcase
        return found;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Payload filler, biased toward the framing bytes to tempt a false header.
    function automatic byte_t filler_byte();
        int unsigned r;
        r = $urandom_range(7);
        if (r == 0)
            return BYTE_CR;
        else if (r == 1)
            return BYTE_LF;
        return byte_t'($urandom);
    endfunction

    // Word values with the extremes mixed in.
    function automatic word_t word_value();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return word_t'($urandom);
    endfunction

    // Any byte but CR and LF.
    function automatic byte_t plain_byte();
        byte_t b;
        do
            b = byte_t'($urandom);
        while (b == BYTE_CR || b == BYTE_LF);
        return b;
    endfunction

    // Header, 24-byte payload with the three kept words, then the given trailer.
    task automatic push_frame(input word_t ang, input word_t px, input word_t py,
                              input byte_t trl1, input byte_t trl2);
        int i;
        byte_stream.push_back(BYTE_CR);
        byte_stream.push_back(BYTE_LF);
        for (i = 0; i < PAYLOAD_BYTES; i++)
        begin
            if (i < 4)
                byte_stream.push_back(ang[8*i +: 8]);
            else if (i >= 12 && i < 16)
                byte_stream.push_back(px[8*(i-12) +: 8]);
            else if (i >= 16 && i < 20)
                byte_stream.push_back(py[8*(i-16) +: 8]);
            else
                byte_stream.push_back(filler_byte());
        end
        byte_stream.push_back(trl1);
        byte_stream.push_back(trl2);
    endtask

    // ------------------------------------------------------------------
    // Idle schedule: first third sender 30% / receiver 64%, second third
    // swapped, last third no idling. Driven by bytes accepted so far.
    // ------------------------------------------------------------------
    function automatic int unsigned idle_pct(input bit sender);
        if (bytes_taken * 3 < stream_len)
            return sender ? 30 : 64;
        else if (bytes_taken * 3 < stream_len * 2)
            return sender ? 64 : 30;
        return 0;
    endfunction

    // Byte driver: offers the next byte once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= '0;
        end
        else
        begin
            if (rx_if.valid && rx_if.ready)
                bytes_taken <= bytes_taken + 1;
            if (!rx_if.valid || rx_if.ready)
            begin
                if (byte_stream.size() != 0 && $urandom_range(99) >= idle_pct(1'b1))
                begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= byte_stream.pop_front();
                end
                else
                    rx_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random backpressure on pos.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_if.ready <= 1'b0;
        else
            pos_if.ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end

    task automatic check_field(input string name, input word_t exp_v, input word_t act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, actual %h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Monitor: checks each emitted frame against the oldest prediction, then
    // feeds the accepted byte (if any) to the model. A frame only appears on pos
    // after its closing CR has passed the input register, so the order here is safe.
    always @(posedge clk)
    begin
        pos_t got;
        pos_t want;
        if (rst_n)
        begin
            if (pos_if.valid && pos_if.ready)
            begin
                got.angle_bits = pos_if.angle_bits;
                got.pos_x_bits = pos_if.pos_x_bits;
                got.pos_y_bits = pos_if.pos_y_bits;
                if (pending_frames.size() == 0)
                begin
                    $error("unexpected frame: angle %h x %h y %h",
                           got.angle_bits, got.pos_x_bits, got.pos_y_bits);
                    mismatches++;
                end
                else
                begin
                    want = pending_frames.pop_front();
                    check_field("angle_bits", want.angle_bits, got.angle_bits);
                    check_field("pos_x_bits", want.pos_x_bits, got.pos_x_bits);
                    check_field("pos_y_bits", want.pos_y_bits, got.pos_y_bits);
                end
            end
            if (rx_if.valid && rx_if.ready)
            begin
                if (parse_byte(rx_if.rx_byte, want))
                    pending_frames.push_back(want);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("position_frame_deframer_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stream build, reset, end of run
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned r;
        int unsigned k;

        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        pos_if.ready  = 1'b0;

        // Directed: noise while hunting, then a bad second header byte
        byte_stream.push_back(8'h00);
        byte_stream.push_back(8'hFF);
        byte_stream.push_back(BYTE_CR);
        byte_stream.push_back(8'h55);
        // repeated CR before LF, extreme words, good frame
        byte_stream.push_back(BYTE_CR);
        byte_stream.push_back(BYTE_CR);
        push_frame('1, '0, 32'h8000_0001, BYTE_LF, BYTE_CR);
        // after a good frame: LF alone does not open a header
        byte_stream.push_back(BYTE_LF);
        // CR in first trailer slot restarts the header; the following LF opens it
        push_frame(32'h3F80_0000, '1, '0, BYTE_CR, BYTE_LF);
        // ...so this is payload of a frame entered via the restart; end it good
        for (k = 0; k < PAYLOAD_BYTES; k++)
            byte_stream.push_back(byte_t'(k * 11));
        byte_stream.push_back(BYTE_LF);
        byte_stream.push_back(BYTE_CR);
        // bad second trailer byte, then bad first trailer byte
        push_frame(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, BYTE_LF, 8'hA5);
        push_frame(32'hDEAD_BEEF, 32'h7F7F_FFFF, 32'hFF80_0000, 8'h77, BYTE_CR);
        byte_stream.push_back(BYTE_LF);
        push_frame('0, '0, '0, BYTE_LF, BYTE_CR);

        // Random: mostly well-formed frames with random content, some broken
        while (byte_stream.size() < STREAM_TARGET)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                if ($urandom_range(3) == 0)
                    byte_stream.push_back(BYTE_CR);
                push_frame(word_value(), word_value(), word_value(), BYTE_LF, BYTE_CR);
            end
            else if (r < 78)
                push_frame(word_value(), word_value(), word_value(),
                           ($urandom_range(1) == 0) ? BYTE_CR : plain_byte(), filler_byte());
            else if (r < 85)
                push_frame(word_value(), word_value(), word_value(), BYTE_LF,
                           ($urandom_range(1) == 0) ? BYTE_LF : plain_byte());
            else if (r < 91)
            begin
                byte_stream.push_back(BYTE_CR);
                byte_stream.push_back(plain_byte());
            end
            else
            begin
                k = $urandom_range(8, 1);
                repeat (k) byte_stream.push_back(filler_byte());
            end
        end
        stream_len = byte_stream.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // All bytes taken and every predicted frame seen
        while (!(bytes_taken == stream_len && pending_frames.size() == 0))
            @(posedge clk);
        // stray frames would show up in the monitor during this pause
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("position_frame_deframer_top regression: pass");
        else
            $display("position_frame_deframer_top regression: fail");
        $finish;
    end

endmodule

// File: sim.f
src/pfd_pkg.sv
src/pfd_byte_if.sv
src/pfd_pos_if.sv
src/pfd_parser.sv
src/pfd_out_stage.sv
src/position_frame_deframer_top.sv
tb/sv/tb_position_frame_deframer_top.sv
